// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while reset is released
`define SMAF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// checked at every edge, reset included
`define SMAF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/smaf_pkg.sv -----
package smaf_pkg;

    localparam int CHANNELS         = 4;
    localparam int FIELD_W          = 12;
    localparam int SAMPLE_COUNT_DEF = 16;
    localparam int SAMPLE_WIDTH_DEF = 12;

    typedef logic [FIELD_W-1:0] t_field;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic sum_mode;
        logic write_new;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic scan_done;
        logic out_free;
    } t_status;

endpackage

// ----- rtl/smaf_in_if.sv -----
interface smaf_in_if import smaf_pkg::*; ();
    logic   valid;
    logic   ready;
    t_field sample_ch0;
    t_field sample_ch1;
    t_field sample_ch2;
    t_field sample_ch3;

    modport source (output valid, output sample_ch0, output sample_ch1,
                    output sample_ch2, output sample_ch3, input ready);
    modport sink   (input valid, input sample_ch0, input sample_ch1,
                    input sample_ch2, input sample_ch3, output ready);
endinterface

// ----- rtl/smaf_out_if.sv -----
interface smaf_out_if import smaf_pkg::*; ();
    logic   valid;
    logic   ready;
    t_field mean_ch0;
    t_field mean_ch1;
    t_field mean_ch2;
    t_field mean_ch3;

    modport source (output valid, output mean_ch0, output mean_ch1,
                    output mean_ch2, output mean_ch3, input ready);
    modport sink   (input valid, input mean_ch0, input mean_ch1,
                    input mean_ch2, input mean_ch3, output ready);
endinterface

// ----- rtl/sorted_middle_average_filter_top.sv -----
// fill request k (k = 0 .. SAMPLE_COUNT-1) runs a rank-compare pass over the k stored
// entries, one memory read per cycle, then one insert write
// the request after a full buffer drops its samples, runs a sum pass over the stored entries,
// puts the result into the output register once that is free, and then takes the next request
// synchronous active-low reset empties the buffers and the output register, no clearing pass
module sorted_middle_average_filter_top import smaf_pkg::*; #(
    parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    smaf_in_if.sink           i_in,
    smaf_out_if.source        o_out
);

    // scheme: instead of sorting in place, every stored entry carries its rank
    // among the entries stored so far (ties rank by arrival order). a new sample
    // is compared against every stored one: each larger stored entry moves up one
    // rank, every other one moves the new sample up. after the last fill the
    // ranks equal the sorted positions, so one sweep sums the entries whose rank
    // lies in the middle window of four

    t_cmd    cmd;
    t_status status;
    t_field  samples [CHANNELS];
    t_field  means   [CHANNELS];

    assign samples[0] = i_in.sample_ch0;
    assign samples[1] = i_in.sample_ch1;
    assign samples[2] = i_in.sample_ch2;
    assign samples[3] = i_in.sample_ch3;

    // sequencer: idle, rank pass, insert, sum pass, emit
    smaf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // buffer memory, rank update, window sums and the output register
    smaf_datapath #(
        .SAMPLE_COUNT (SAMPLE_COUNT),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_samples   (samples),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_means     (means)
    );

    // results stay in the output register while the next round fills
    assign o_out.mean_ch0 = means[0];
    assign o_out.mean_ch1 = means[1];
    assign o_out.mean_ch2 = means[2];
    assign o_out.mean_ch3 = means[3];

endmodule

// ----- rtl/smaf_ram.sv -----
module smaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/smaf_ctrl.sv -----
module smaf_ctrl import smaf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RANK  = 5'b00010,
        S_WRITE = 5'b00100,
        S_SUM   = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.start = 1'b1;
                    n_state     = i_status.full ? S_SUM : S_RANK;
                end
            end
            S_RANK: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write_new = 1'b1;
                n_state         = S_IDLE;
            end
            S_SUM: begin
                o_cmd.scan     = 1'b1;
                o_cmd.sum_mode = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // no request is taken while reset is held
    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;

endmodule

// ----- rtl/smaf_datapath.sv -----
`include "assert_macros.svh"

module smaf_datapath import smaf_pkg::*; #(
    parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    output t_status o_status,
    input  t_field  i_samples [CHANNELS],
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_field  o_means [CHANNELS]
);

    localparam int AW      = $clog2(SAMPLE_COUNT);
    localparam int CW      = $clog2(SAMPLE_COUNT + 1);
    localparam int RW      = AW;
    localparam int ENTRY_W = RW + SAMPLE_WIDTH;
    localparam int WORD_W  = CHANNELS * ENTRY_W;
    localparam int SUM_W   = SAMPLE_WIDTH + 2;
    localparam int MID     = SAMPLE_COUNT / 2;

    localparam logic [RW-1:0] RANK_LO = RW'(MID - 2);
    localparam logic [RW-1:0] RANK_HI = RW'(MID + 1);
    localparam logic [CW-1:0] FULL    = CW'(SAMPLE_COUNT);

    logic [CW-1:0]           r_fill;
    logic [CW-1:0]           r_addr;
    logic                    r_pend;
    logic [AW-1:0]           r_pend_addr;
    logic [SAMPLE_WIDTH-1:0] r_new      [CHANNELS];
    logic [RW-1:0]           r_new_rank [CHANNELS];
    logic [SUM_W-1:0]        r_sum      [CHANNELS];
    logic                    r_out_valid;
    t_field                  r_mean     [CHANNELS];

    logic                    issue;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [WORD_W-1:0]       wr_data;
    logic [WORD_W-1:0]       rd_data;
    logic [SAMPLE_WIDTH-1:0] rd_val     [CHANNELS];
    logic [RW-1:0]           rd_rank    [CHANNELS];
    logic                    greater    [CHANNELS];
    logic                    in_window  [CHANNELS];

    // one word holds {rank, value} for all channels at the same index
    smaf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SAMPLE_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (issue),
        .i_rd_addr (r_addr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign issue = i_cmd.scan && (r_addr < r_fill);

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            rd_val[c]    = rd_data[c*ENTRY_W +: SAMPLE_WIDTH];
            rd_rank[c]   = rd_data[c*ENTRY_W+SAMPLE_WIDTH +: RW];
            greater[c]   = rd_val[c] > r_new[c];
            in_window[c] = (rd_rank[c] >= RANK_LO) && (rd_rank[c] <= RANK_HI);
        end
    end

    // rank pass writes back the bumped rank, the insert writes the new entry
    always_comb begin
        wr_en   = i_cmd.write_new || (i_cmd.scan && !i_cmd.sum_mode && r_pend);
        wr_addr = i_cmd.write_new ? r_fill[AW-1:0] : r_pend_addr;
        for (int c = 0; c < CHANNELS; c++) begin
            if (i_cmd.write_new) begin
                wr_data[c*ENTRY_W +: ENTRY_W] = {r_new_rank[c], r_new[c]};
            end else begin
                wr_data[c*ENTRY_W +: ENTRY_W] =
                    {greater[c] ? rd_rank[c] + RW'(1) : rd_rank[c], rd_val[c]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_addr      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_addr <= '0;
                r_pend <= 1'b0;
            end else if (i_cmd.scan) begin
                r_pend <= issue;
                if (issue) begin
                    r_addr <= r_addr + CW'(1);
                end
            end
            if (i_cmd.write_new) begin
                r_fill <= r_fill + CW'(1);
            end else if (i_cmd.emit) begin
                r_fill <= '0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pend_addr <= r_addr[AW-1:0];
        end
        for (int c = 0; c < CHANNELS; c++) begin
            if (i_cmd.start) begin
                r_new[c]      <= SAMPLE_WIDTH'(i_samples[c]);
                r_new_rank[c] <= '0;
                r_sum[c]      <= '0;
            end else if (i_cmd.scan && r_pend) begin
                if (i_cmd.sum_mode) begin
                    if (in_window[c]) begin
                        r_sum[c] <= r_sum[c] + SUM_W'(rd_val[c]);
                    end
                end else if (!greater[c]) begin
                    r_new_rank[c] <= r_new_rank[c] + RW'(1);
                end
            end
            if (i_cmd.emit) begin
                r_mean[c] <= FIELD_W'(r_sum[c][SUM_W-1:2]);
            end
        end
    end

    assign o_status.full      = (r_fill == FULL);
    assign o_status.scan_done = !r_pend && (r_addr == r_fill);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_means     = r_mean;

    `SMAF_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= FULL, "fill count past depth")
    `SMAF_ASSERT(a_pend_below_fill, i_clk, i_rst_n, r_pend |-> (CW'(r_pend_addr) < r_fill), "read past filled entries")
    `SMAF_ASSERT(a_insert_after_scan, i_clk, i_rst_n, i_cmd.write_new |-> (!r_pend && (r_addr == r_fill)), "insert before rank pass ended")
    `SMAF_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (r_fill == '0 && !r_out_valid), "reset left state behind")

endmodule

// ----- sim/testbench.sv -----
module testbench import smaf_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // block geometry, as built with its default parameters
    localparam int NUM_SAMPLES = SAMPLE_COUNT_DEF;
    localparam int SAMPLE_BITS = SAMPLE_WIDTH_DEF;
    localparam t_field SAMPLE_MASK = t_field'((1 << SAMPLE_BITS) - 1);
    localparam t_field FULL_SCALE = '1;

    // run shape
    localparam int unsigned RANDOM_REQUESTS = 1730;
    localparam int unsigned HOLD_AT = 500;          // request count that starts the long hold-off
    localparam int unsigned HOLD_CYCLES = 700;      // length of that hold-off
    localparam int unsigned PAUSE_AT = 1100;        // request count that starts the drain pause
    localparam int unsigned IDLE_LIMIT = 4000;      // cycles with no handshake before giving up
    localparam int unsigned END_DRAIN = 4 * NUM_SAMPLES + 40;

    // one sample or one mean per channel, channel 0 in the low slot
    typedef logic [CHANNELS-1:0][FIELD_W-1:0] t_quad;

    // how the samples of one round are drawn
    typedef enum int {
        STYLE_UNIFORM,
        STYLE_CLUSTER,
        STYLE_EXTREME,
        STYLE_REPEAT
    } t_style;

    // how the receiver paces its ready
    typedef enum int {
        READY_STEADY,
        READY_BLOCKED,
        READY_RANDOM
    } t_pace;

    // trimmed-mean predictor plus the queue of means still owed by the block
    class mean_scoreboard;
        t_field      bank [CHANNELS][NUM_SAMPLES];
        int unsigned fill;
        t_quad       expected_means [$];
        int unsigned errors;

        function new();
            fill = 0;
            errors = 0;
        endfunction

        function int unsigned pending();
            return expected_means.size();
        endfunction

        function int unsigned fill_level();
            return fill;
        endfunction

        // ascending sort of one channel, then floor of the four middle entries over four
        function t_field trimmed_mean(input int ch);
            t_field ranked [NUM_SAMPLES];
            t_field swap;
            logic [FIELD_W+1:0] sum;
            int mid;
            for (int i = 0; i < NUM_SAMPLES; i++)
                ranked[i] = bank[ch][i];
            for (int a = 0; a < NUM_SAMPLES; a++) begin
                for (int b = a + 1; b < NUM_SAMPLES; b++) begin
                    if (ranked[a] > ranked[b]) begin
                        swap = ranked[a];
                        ranked[a] = ranked[b];
                        ranked[b] = swap;
                    end
                end
            end
            mid = NUM_SAMPLES / 2;
            sum = ranked[mid-2] + ranked[mid-1] + ranked[mid] + ranked[mid+1];
            return sum[FIELD_W+1:2] & SAMPLE_MASK;
        endfunction

        // full buffers: samples dropped, one set of means owed; otherwise store
        function void note_samples(input t_quad samples);
            t_quad means;
            if (fill == NUM_SAMPLES) begin
                for (int ch = 0; ch < CHANNELS; ch++)
                    means[ch] = trimmed_mean(ch);
                expected_means.push_back(means);
                fill = 0;
            end else begin
                for (int ch = 0; ch < CHANNELS; ch++)
                    bank[ch][fill] = samples[ch] & SAMPLE_MASK;
                fill++;
            end
        endfunction

        task report(input string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_means(input t_quad got);
            t_quad want;
            if (expected_means.size() == 0) begin
                report($sformatf("means %h arrived with none owed", got));
                return;
            end
            want = expected_means.pop_front();
            for (int ch = 0; ch < CHANNELS; ch++) begin
                if (got[ch] !== want[ch])
                    report($sformatf("mean_ch%0d got %0d, want %0d", ch, got[ch], want[ch]));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    smaf_in_if  in_bus ();
    smaf_out_if out_bus ();

    mean_scoreboard mean_predictor = new();

    int unsigned requests_sent = 0;
    int unsigned quiet_cycles = 0;
    bit          hold_done = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    sorted_middle_average_filter_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // present one request and hold it until the block takes it
    task automatic offer_request(input t_quad samples);
        in_bus.valid      <= 1'b1;
        in_bus.sample_ch0 <= samples[0];
        in_bus.sample_ch1 <= samples[1];
        in_bus.sample_ch2 <= samples[2];
        in_bus.sample_ch3 <= samples[3];
        do
            @(posedge i_clk);
        while (in_bus.ready !== 1'b1);
        mean_predictor.note_samples(samples);
        requests_sent++;
    endtask

    // drop valid for a number of cycles; zero leaves the burst running
    task automatic idle_gap(input int unsigned cycles);
        if (cycles != 0) begin
            in_bus.valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // one sample for a round of the given style, around a per-channel center
    function automatic t_field draw_sample(input t_style style, input t_field center);
        int level;
        case (style)
            STYLE_CLUSTER: begin
                // tight spread, lots of near-ties around the center
                level = int'(center) + int'($urandom_range(0, 30)) - 15;
                if (level < 0)
                    level = 0;
                if (level > int'(FULL_SCALE))
                    level = int'(FULL_SCALE);
                return t_field'(level);
            end
            STYLE_EXTREME: begin
                // rails and their neighbors
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return FULL_SCALE;
                    2: return t_field'($urandom_range(0, 3));
                    default: return FULL_SCALE - t_field'($urandom_range(0, 3));
                endcase
            end
            STYLE_REPEAT: begin
                // only a few distinct values, so the middle entries are often equal
                case ($urandom_range(0, 2))
                    0: return center;
                    1: return ~center;
                    default: return center ^ 12'h0f0;
                endcase
            end
            default: return t_field'($urandom_range(0, int'(FULL_SCALE)));
        endcase
    endfunction

    // every accepted result is checked against the oldest owed set of means
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
            mean_predictor.check_means({out_bus.mean_ch3, out_bus.mean_ch2,
                                        out_bus.mean_ch1, out_bus.mean_ch0});
    end

    // watchdog: any handshake on either side restarts the count
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
            (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: its own stall pattern, plus one long hold-off that backs the block up
    initial begin
        t_pace       pace;
        int unsigned span;
        out_bus.ready <= 1'b0;
        do
            @(posedge i_clk);
        while (i_rst_n !== 1'b1);
        forever begin
            if (!hold_done && requests_sent >= HOLD_AT) begin
                // sender keeps offering meanwhile, so the input side stalls too
                hold_done = 1'b1;
                out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                pace = t_pace'($urandom_range(0, 2));
                span = (pace == READY_BLOCKED) ? $urandom_range(1, 25) : $urandom_range(1, 40);
                repeat (span) begin
                    case (pace)
                        READY_STEADY:  out_bus.ready <= 1'b1;
                        READY_BLOCKED: out_bus.ready <= 1'b0;
                        default:       out_bus.ready <= 1'($urandom_range(0, 1));
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // sender: reset, one directed round, then random rounds in bursts
    initial begin
        t_quad       samples;
        t_style      style;
        t_field      center [CHANNELS];
        int unsigned burst_left;
        bit          paused;

        burst_left = 0;
        paused = 1'b0;
        style = STYLE_UNIFORM;
        for (int ch = 0; ch < CHANNELS; ch++)
            center[ch] = '0;

        i_rst_n           <= 1'b0;
        in_bus.valid      <= 1'b0;
        in_bus.sample_ch0 <= '0;
        in_bus.sample_ch1 <= '0;
        in_bus.sample_ch2 <= '0;
        in_bus.sample_ch3 <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed round: channel 0 at full scale, channel 1 at zero,
        // channel 2 a descending ramp from full scale to zero, channel 3
        // alternating between the rails so the middle straddles the jump
        for (int k = 0; k < NUM_SAMPLES; k++) begin
            samples[0] = FULL_SCALE;
            samples[1] = '0;
            samples[2] = FULL_SCALE - t_field'(k * 273);
            samples[3] = k[0] ? FULL_SCALE : '0;
            idle_gap(k % 3);
            offer_request(samples);
        end
        // the request that finds the buffers full: its samples must be ignored
        samples = {CHANNELS{FULL_SCALE}};
        offer_request(samples);
        samples = '0;
        offer_request(samples);

        for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
            // new style and centers at the start of every round
            if (mean_predictor.fill_level() == 0) begin
                style = t_style'($urandom_range(0, 3));
                for (int ch = 0; ch < CHANNELS; ch++)
                    center[ch] = t_field'($urandom_range(0, int'(FULL_SCALE)));
            end
            for (int ch = 0; ch < CHANNELS; ch++)
                samples[ch] = draw_sample(style, center[ch]);

            // bursts of random length, gaps between them, often none at all
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 30);
                idle_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
            end
            burst_left--;
            offer_request(samples);

            // once, right after a full-buffer request, wait for the block to drain
            if (!paused && requests_sent >= PAUSE_AT && mean_predictor.pending() != 0) begin
                paused = 1'b1;
                in_bus.valid <= 1'b0;
                while (mean_predictor.pending() != 0)
                    @(posedge i_clk);
            end
        end
        in_bus.valid <= 1'b0;

        // all owed means in, then a quiet stretch to catch any stray result
        while (mean_predictor.pending() != 0)
            @(posedge i_clk);
        repeat (END_DRAIN) @(posedge i_clk);

        if (mean_predictor.errors == 0 && mean_predictor.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
